// ===== rtl/core/srdc_pkg.sv =====
package srdc_pkg;

    localparam int NUM_REGS   = 48;
    localparam int IDX_W      = $clog2(NUM_REGS);
    localparam int CNT_W      = $clog2(NUM_REGS + 1);

    localparam int REG_W      = 6;
    localparam int DATA_W     = 16;
    localparam int LINE_W     = 8;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 16;
    localparam int STAT_IDX_W = 6;

    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 3;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 2;

    localparam logic [LINE_W-1:0]     BLANK_LOW_RST  = 8'd160;
    localparam logic [LINE_W-1:0]     BLANK_HIGH_RST = 8'd226;
    localparam logic [STAT_IDX_W-1:0] STAT_IDX_RST   = 6'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE    = 3'd0,
        OP_WRITE_FB = 3'd1,
        OP_SET      = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_READ     = 3'd4,
        OP_FLUSH    = 3'd5
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLANK_LOW  = 2'd0,
        CFG_BLANK_HIGH = 2'd1,
        CFG_STATUS_IDX = 2'd2,
        CFG_MERGE_MASK = 2'd3
    } t_cfg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_FL_LIST,
        ST_FL_SH,
        ST_FL_EMIT
    } t_state;

endpackage

// ===== rtl/core/shadow_register_deferred_commit.sv =====
// write, set, clear and read items go from acceptance through the look and execute states,
// where a result is loaded; a new item is taken only back in idle, paced by the sequencer and the shadow read port
// a flush walks the pending list one entry at a time: list read, shadow read, emit
// the output register lets the next request in while a result waits to be taken
// synchronous active-low reset: shadow store reads as zero, pending list empty,
// window and status index back to their defaults
module shadow_register_deferred_commit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // reg_index[5:0], value[21:6], scanline[29:22], forced_blank[30], zero[31]
    input  logic [srdc_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation[2:0]
    input  logic [srdc_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // commit_index[5:0], commit_data[21:6], read_data[37:22], zero[39:38]
    output logic [srdc_pkg::M_TDATA_W-1:0]   m_tdata,
    // commit_valid[0], merge_status[1]
    output logic [srdc_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                             m_tlast,
    input  logic                             i_cfg_we,
    input  logic [srdc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [srdc_pkg::CFG_W-1:0]       i_cfg_data
);
    import srdc_pkg::*;

    // control
    t_state                  r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic [IDX_W-1:0]        r_fl_i, n_fl_i;
    logic [NUM_REGS-1:0]     r_flags, n_flags;
    logic [NUM_REGS-1:0]     r_shv, n_shv;
    logic [LINE_W-1:0]       r_blank_low, n_blank_low;
    logic [LINE_W-1:0]       r_blank_high, n_blank_high;
    logic [STAT_IDX_W-1:0]   r_status_idx, n_status_idx;

    // latched request
    t_op                     r_op;
    logic [REG_W-1:0]        r_idx;
    logic [DATA_W-1:0]       r_val;
    logic [LINE_W-1:0]       r_line;
    logic                    r_fb;

    // output register
    logic                    r_m_valid, n_m_valid;
    logic                    r_m_cv, n_m_cv;
    logic                    r_m_merge, n_m_merge;
    logic                    r_m_last, n_m_last;
    logic [REG_W-1:0]        r_m_idx, n_m_idx;
    logic [DATA_W-1:0]       r_m_cdata, n_m_cdata;
    logic [DATA_W-1:0]       r_m_rdata, n_m_rdata;

    // memories
    logic [DATA_W-1:0]       r_shadow_mem [NUM_REGS];
    logic [IDX_W-1:0]        r_plist_mem  [NUM_REGS];
    logic [DATA_W-1:0]       r_sh_q;
    logic                    r_sh_ok;
    logic [IDX_W-1:0]        r_pl_q;

    logic                    in_accept;
    logic                    in_range;
    logic                    commit_now;
    logic                    out_free;
    logic                    fl_last;
    logic [DATA_W-1:0]       old_val;
    logic [DATA_W-1:0]       new_val;
    logic [IDX_W-1:0]        sh_ra;
    logic                    sh_ok;
    logic                    sh_we;
    logic                    pl_we;

    assign s_tready  = (r_state == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !r_m_valid || m_tready;

    assign in_range  = ({1'b0, r_idx} < (REG_W + 1)'(NUM_REGS));
    assign old_val   = r_sh_ok ? r_sh_q : '0;
    // strictly inside the blanking window, or forced blank; a forced-blank-only write needs forced blank
    assign commit_now = (r_op == OP_WRITE_FB) ? r_fb
                      : (((r_line > r_blank_low) && (r_line < r_blank_high)) || r_fb);
    assign fl_last   = (CNT_W'(r_fl_i) == (r_cnt - CNT_W'(1)));

    always_comb begin
        case (r_op)
            OP_SET:   new_val = old_val | r_val;
            OP_CLEAR: new_val = old_val & ~r_val;
            default:  new_val = r_val;
        endcase
    end

    // shared shadow read port: request index or pending list entry,
    // the list entry is held while an emit waits for the output
    always_comb begin
        if (r_state == ST_FL_SH || r_state == ST_FL_EMIT) begin
            sh_ra = r_pl_q;
            sh_ok = r_shv[r_pl_q];
        end else begin
            sh_ra = IDX_W'(r_idx);
            sh_ok = in_range && r_shv[IDX_W'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (sh_we) begin
            r_shadow_mem[IDX_W'(r_idx)] <= new_val;
        end
        r_sh_q  <= r_shadow_mem[sh_ra];
        r_sh_ok <= sh_ok;
    end

    always_ff @(posedge i_clk) begin
        if (pl_we) begin
            r_plist_mem[IDX_W'(r_cnt)] <= IDX_W'(r_idx);
        end
        r_pl_q <= r_plist_mem[r_fl_i];
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_fl_i       = r_fl_i;
        n_flags      = r_flags;
        n_shv        = r_shv;
        n_blank_low  = r_blank_low;
        n_blank_high = r_blank_high;
        n_status_idx = r_status_idx;
        n_m_valid    = r_m_valid && !m_tready;
        n_m_cv       = r_m_cv;
        n_m_merge    = r_m_merge;
        n_m_last     = r_m_last;
        n_m_idx      = r_m_idx;
        n_m_cdata    = r_m_cdata;
        n_m_rdata    = r_m_rdata;
        sh_we        = 1'b0;
        pl_we        = 1'b0;

        if (i_cfg_we) begin
            unique case (t_cfg'(i_cfg_index))
                CFG_BLANK_LOW:  n_blank_low  = i_cfg_data[LINE_W-1:0];
                CFG_BLANK_HIGH: n_blank_high = i_cfg_data[LINE_W-1:0];
                CFG_STATUS_IDX: n_status_idx = i_cfg_data[STAT_IDX_W-1:0];
                // merge mask writes are accepted but not stored by this block
                CFG_MERGE_MASK: ;
                default: ;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (r_op == OP_FLUSH) begin
                    if (r_cnt == '0) begin
                        n_state = ST_IDLE;
                    end else begin
                        // every flagged register is in the list, so all flags drop
                        n_flags = '0;
                        n_fl_i  = '0;
                        n_state = ST_FL_LIST;
                    end
                end else begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (r_op) inside
                    OP_READ: begin
                        if (out_free) begin
                            n_m_valid = 1'b1;
                            n_m_cv    = 1'b0;
                            n_m_merge = 1'b0;
                            n_m_last  = 1'b1;
                            n_m_idx   = '0;
                            n_m_cdata = '0;
                            n_m_rdata = old_val;
                            n_state   = ST_IDLE;
                        end
                    end
                    OP_WRITE, OP_WRITE_FB, OP_SET, OP_CLEAR: begin
                        if (!in_range) begin
                            n_state = ST_IDLE;
                        end else if (commit_now) begin
                            if (out_free) begin
                                sh_we                    = 1'b1;
                                n_shv[IDX_W'(r_idx)]     = 1'b1;
                                n_m_valid                = 1'b1;
                                n_m_cv                   = 1'b1;
                                n_m_merge                = (r_idx == r_status_idx);
                                n_m_last                 = 1'b1;
                                n_m_idx                  = r_idx;
                                n_m_cdata                = new_val;
                                n_m_rdata                = '0;
                                n_state                  = ST_IDLE;
                            end
                        end else begin
                            sh_we                = 1'b1;
                            n_shv[IDX_W'(r_idx)] = 1'b1;
                            if (!r_flags[IDX_W'(r_idx)] && (r_cnt < CNT_W'(NUM_REGS))) begin
                                pl_we                  = 1'b1;
                                n_flags[IDX_W'(r_idx)] = 1'b1;
                                n_cnt                  = r_cnt + CNT_W'(1);
                            end
                            n_state = ST_IDLE;
                        end
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_FL_LIST: n_state = ST_FL_SH;
            ST_FL_SH:   n_state = ST_FL_EMIT;
            ST_FL_EMIT: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_cv    = 1'b1;
                    n_m_merge = (REG_W'(r_pl_q) == r_status_idx);
                    n_m_last  = fl_last;
                    n_m_idx   = REG_W'(r_pl_q);
                    n_m_cdata = old_val;
                    n_m_rdata = '0;
                    if (fl_last) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_fl_i  = r_fl_i + IDX_W'(1);
                        n_state = ST_FL_LIST;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_fl_i       <= '0;
            r_flags      <= '0;
            r_shv        <= '0;
            r_blank_low  <= BLANK_LOW_RST;
            r_blank_high <= BLANK_HIGH_RST;
            r_status_idx <= STAT_IDX_RST;
            r_m_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_fl_i       <= n_fl_i;
            r_flags      <= n_flags;
            r_shv        <= n_shv;
            r_blank_low  <= n_blank_low;
            r_blank_high <= n_blank_high;
            r_status_idx <= n_status_idx;
            r_m_valid    <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op   <= t_op'(s_tuser[OP_W-1:0]);
            r_idx  <= s_tdata[5:0];
            r_val  <= s_tdata[21:6];
            r_line <= s_tdata[29:22];
            r_fb   <= s_tdata[30];
        end
        r_m_cv    <= n_m_cv;
        r_m_merge <= n_m_merge;
        r_m_last  <= n_m_last;
        r_m_idx   <= n_m_idx;
        r_m_cdata <= n_m_cdata;
        r_m_rdata <= n_m_rdata;
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {2'b00, r_m_rdata, r_m_cdata, r_m_idx};
    assign m_tuser  = {r_m_merge, r_m_cv};
    assign m_tlast  = r_m_last;

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(NUM_REGS))
        else $error("pending count beyond register count");

    a_flags_match_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE || r_state == ST_LOOK || r_state == ST_EXEC)
        |-> ($countones(r_flags) == int'(r_cnt)))
        else $error("pending flags disagree with pending count");

    a_emit_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FL_EMIT) |-> ((r_cnt != '0) && (CNT_W'(r_fl_i) < r_cnt)))
        else $error("flush walks beyond the pending list");

    a_flush_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FL_EMIT && out_free && fl_last) |=> (r_cnt == '0))
        else $error("pending list not emptied after flush");
`endif

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import srdc_pkg::*;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [REG_W-1:0]  idx;
        logic [DATA_W-1:0] val;
        logic [LINE_W-1:0] line;
        logic              fb;
        int                gap;
        bit                drain;
    } display_req_t;

    typedef struct {
        logic              cv;
        logic [REG_W-1:0]  idx;
        logic [DATA_W-1:0] data;
        logic              merge;
        logic [DATA_W-1:0] rd;
        logic              is_last;
    } reg_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic [DATA_W-1:0]    shadow [NUM_REGS];
    logic                 deferred [NUM_REGS];
    logic [REG_W-1:0]     defer_list [$];
    logic [LINE_W-1:0]    win_lo;
    logic [LINE_W-1:0]    win_hi;
    logic [STAT_IDX_W-1:0] stat_idx;
    logic [DATA_W-1:0]    merge_mask;

    display_req_t display_reqs [$];
    reg_result_t  owed_results [$];

    logic took_req = 1'b0;
    logic took_res = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   src_max_gap = 13;
    int   snk_max_stall = 13;

    int mismatches = 0;
    int n_reqs = 0;
    int n_reads = 0;
    int n_commits = 0;
    int n_cfg_writes = 0;
    int longest_flush = 0;

    shadow_register_deferred_commit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic void push_commit(logic [REG_W-1:0] idx, logic is_last);
        owed_results.push_back(reg_result_t'{1'b1, idx, shadow[idx],
                                             idx == stat_idx, 16'd0, is_last});
        n_commits++;
    endfunction

    task automatic track_shadow_update(input logic [OP_W-1:0] op,
                                       input logic [REG_W-1:0] idx,
                                       input logic [DATA_W-1:0] val,
                                       input logic [LINE_W-1:0] line,
                                       input logic fb);
        logic [DATA_W-1:0] nv;
        logic              now;
        int                n;
        n_reqs++;
        case (op)
            OP_FLUSH: begin
                n = defer_list.size();
                foreach (defer_list[i]) begin
                    push_commit(defer_list[i], i == n - 1);
                    deferred[defer_list[i]] = 1'b0;
                end
                defer_list.delete();
                if (n > longest_flush) longest_flush = n;
            end
            OP_READ: begin
                owed_results.push_back(reg_result_t'{1'b0, 6'd0, 16'd0, 1'b0,
                    (idx < NUM_REGS) ? shadow[idx] : 16'd0, 1'b1});
                n_reads++;
            end
            OP_WRITE, OP_WRITE_FB, OP_SET, OP_CLEAR: begin
                if (idx < NUM_REGS) begin
                    case (op)
                        OP_SET:   nv = shadow[idx] | val;
                        OP_CLEAR: nv = shadow[idx] & ~val;
                        default:  nv = val;
                    endcase
                    shadow[idx] = nv;
                    // the forced-blank-only write ignores the scanline window
                    now = fb || (op != OP_WRITE_FB && line > win_lo && line < win_hi);
                    if (now) begin
                        push_commit(idx, 1'b1);
                    end else if (!deferred[idx]) begin
                        deferred[idx] = 1'b1;
                        defer_list.push_back(idx);
                    end
                end
            end
            default: ;
        endcase
    endtask

    function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                        logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // monitor: results are compared before the new request is predicted
    always @(posedge i_clk) begin
        reg_result_t e;
        if (!i_rst_n) begin
            took_req <= 1'b0;
            took_res <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                n_cfg_writes++;
                case (t_cfg'(i_cfg_index))
                    CFG_BLANK_LOW:  win_lo = i_cfg_data[LINE_W-1:0];
                    CFG_BLANK_HIGH: win_hi = i_cfg_data[LINE_W-1:0];
                    CFG_STATUS_IDX: stat_idx = i_cfg_data[STAT_IDX_W-1:0];
                    CFG_MERGE_MASK: merge_mask = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result: tdata 0x%0h tuser 0x%0h", m_tdata, m_tuser);
                    mismatches++;
                end else begin
                    e = owed_results.pop_front();
                    check_field("commit_valid", e.cv, m_tuser[0]);
                    check_field("commit_index", e.idx, m_tdata[5:0]);
                    check_field("commit_data", e.data, m_tdata[21:6]);
                    check_field("merge_status", e.merge, m_tuser[1]);
                    check_field("read_data", e.rd, m_tdata[37:22]);
                    check_field("last", e.is_last, m_tlast);
                end
            end
            if (s_tvalid && s_tready)
                track_shadow_update(s_tuser, s_tdata[5:0], s_tdata[21:6],
                                    s_tdata[29:22], s_tdata[30]);
            took_req <= s_tvalid && s_tready;
            took_res <= m_tvalid && m_tready;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        display_req_t r;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (s_tvalid && !took_req) begin
            // request still waiting for the block
        end else if (gap_left != 0) begin
            s_tvalid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (display_reqs.size() != 0 &&
                     !(display_reqs[0].drain && owed_results.size() != 0)) begin
            r = display_reqs.pop_front();
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, r.fb, r.line, r.val, r.idx};
            s_tuser  <= r.op;
            gap_left <= r.gap;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result sink: a fresh stall is drawn after every result taken
    always @(negedge i_clk) begin
        int k;
        if (!i_rst_n) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (took_res) begin
            k = $urandom_range(0, snk_max_stall);
            stall_left <= k;
            m_tready   <= (k == 0);
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end
    end

    task automatic add_req(input logic [OP_W-1:0] op, input logic [REG_W-1:0] idx,
                           input logic [DATA_W-1:0] val, input logic [LINE_W-1:0] line,
                           input logic fb);
        display_reqs.push_back(display_req_t'{op, idx, val, line, fb,
                                              $urandom_range(0, src_max_gap), 1'b0});
    endtask

    task automatic add_random_req();
        int               pick;
        logic [OP_W-1:0]  op;
        logic [REG_W-1:0] idx;
        logic [LINE_W-1:0] line;
        pick = $urandom_range(0, 99);
        if (pick < 30)      op = OP_WRITE;
        else if (pick < 40) op = OP_WRITE_FB;
        else if (pick < 52) op = OP_SET;
        else if (pick < 64) op = OP_CLEAR;
        else if (pick < 80) op = OP_READ;
        else if (pick < 87) op = OP_FLUSH;
        else if (pick < 90) op = OP_W'(3'd6 + $urandom_range(0, 1));
        else                op = OP_WRITE;
        idx = ($urandom_range(0, 19) == 0) ? REG_W'($urandom_range(NUM_REGS, 63))
                                           : REG_W'($urandom_range(0, NUM_REGS - 1));
        // lean on the window edges half of the time
        case ($urandom_range(0, 3))
            0:       line = LINE_W'(win_lo + $urandom_range(0, 2));
            1:       line = LINE_W'(win_hi - $urandom_range(0, 2));
            default: line = LINE_W'($urandom);
        endcase
        add_req(op, idx, DATA_W'($urandom), line, $urandom_range(0, 4) == 0);
    endtask

    task automatic write_cfg(input t_cfg which, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= which;
        i_cfg_data  <= data;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // block is idle once every request is taken and every result has come
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
            #1;
        end while (display_reqs.size() != 0 || s_tvalid || owed_results.size() != 0);
        repeat (16) @(posedge i_clk);
    endtask

    initial begin
        int lo, hi, si, mm, j, tmp;
        int order [NUM_REGS];
        foreach (shadow[i]) begin
            shadow[i]   = '0;
            deferred[i] = 1'b0;
        end
        win_lo     = BLANK_LOW_RST;
        win_hi     = BLANK_HIGH_RST;
        stat_idx   = STAT_IDX_RST;
        merge_mask = 16'd24;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part under the reset window 160..226
        add_req(OP_READ,     6'd0,  16'h1234, 8'd0,   1'b0);
        add_req(OP_WRITE,    6'd0,  16'hFFFF, 8'd0,   1'b0);
        add_req(OP_WRITE,    6'd47, 16'h0000, 8'd255, 1'b0);
        add_req(OP_WRITE,    6'd2,  16'hAAAA, 8'd161, 1'b0);
        add_req(OP_WRITE,    6'd5,  16'h5555, 8'd160, 1'b0);
        add_req(OP_WRITE,    6'd5,  16'h0F0F, 8'd226, 1'b0);
        add_req(OP_WRITE,    6'd6,  16'h8001, 8'd225, 1'b0);
        add_req(OP_WRITE_FB, 6'd7,  16'h7FFE, 8'd200, 1'b0);
        add_req(OP_WRITE_FB, 6'd8,  16'hFFFF, 8'd0,   1'b1);
        add_req(OP_SET,      6'd0,  16'h0F00, 8'd0,   1'b1);
        add_req(OP_CLEAR,    6'd0,  16'h00FF, 8'd100, 1'b0);
        add_req(OP_WRITE,    6'd48, 16'hFFFF, 8'd200, 1'b1);
        add_req(OP_SET,      6'd63, 16'hFFFF, 8'd0,   1'b0);
        add_req(OP_CLEAR,    6'd50, 16'hFFFF, 8'd0,   1'b0);
        add_req(OP_READ,     6'd63, 16'h0000, 8'd255, 1'b1);
        add_req(OP_READ,     6'd47, 16'h0000, 8'd0,   1'b0);
        add_req(3'd6,        6'd1,  16'hFFFF, 8'd200, 1'b1);
        add_req(3'd7,        6'd63, 16'hFFFF, 8'd255, 1'b1);
        add_req(OP_FLUSH,    6'd0,  16'h0000, 8'd0,   1'b0);
        add_req(OP_FLUSH,    6'd63, 16'hFFFF, 8'd255, 1'b1);
        add_req(OP_WRITE,    6'd2,  16'h0018, 8'd10,  1'b0);
        add_req(OP_FLUSH,    6'd0,  16'h0000, 8'd0,   1'b0);
        add_req(OP_READ,     6'd2,  16'h0000, 8'd0,   1'b0);
        add_req(OP_READ,     6'd0,  16'h0000, 8'd0,   1'b0);
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin lo = 0;   hi = 255; si = 0;  mm = 16'h0000; end
                1: begin lo = 255; hi = 0;   si = 47; mm = 16'hFFFF; end
                2: begin
                    lo = $urandom_range(0, 255);
                    hi = $urandom_range(0, 255);
                    si = $urandom_range(0, NUM_REGS - 1);
                    mm = $urandom_range(0, 65535);
                end
                3: begin lo = 100; hi = 102; si = 31; mm = 16'h8001; end
                default: begin lo = 160; hi = 226; si = 2; mm = 16'd24; end
            endcase
            write_cfg(CFG_BLANK_LOW, CFG_W'(lo));
            write_cfg(CFG_BLANK_HIGH, CFG_W'(hi));
            write_cfg(CFG_STATUS_IDX, CFG_W'(si));
            write_cfg(CFG_MERGE_MASK, CFG_W'(mm));
            src_max_gap   = (ph == 1 || ph == 3) ? 0 : 13;
            snk_max_stall = (ph == 1 || ph == 2) ? 0 : 13;
            @(negedge i_clk);

            if (ph == 1) begin
                // window is empty here: defer every register, then one full flush
                foreach (order[i]) order[i] = i;
                for (int i = NUM_REGS - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = order[i];
                    order[i] = order[j];
                    order[j] = tmp;
                end
                foreach (order[i])
                    add_req(OP_W'(OP_WRITE + $urandom_range(0, 3)), REG_W'(order[i]),
                            DATA_W'($urandom), LINE_W'($urandom), 1'b0);
                add_req(OP_FLUSH, REG_W'($urandom), DATA_W'($urandom),
                        LINE_W'($urandom), 1'b0);
            end
            for (int i = 0; i < 80; i++) begin
                add_random_req();
                if (ph == 2 && i == 45) display_reqs[$].drain = 1'b1;
            end
            wait_idle();
        end

        repeat (160) @(posedge i_clk);
        $display("covered %0d requests and %0d results (%0d reads, %0d commits)",
                 n_reqs, n_reads + n_commits, n_reads, n_commits);
        $display("longest flush %0d entries, %0d register writes",
                 longest_flush, n_cfg_writes);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== shadow_register_deferred_commit.f =====
rtl/core/srdc_pkg.sv
rtl/core/shadow_register_deferred_commit.sv
tb/sv/tb.sv
